/* sv/strided_nd_address_generator_assert.svh */
// assertion macros used by the port-level checker
`ifndef STRIDED_ND_ADDRESS_GENERATOR_ASSERT_SVH
`define STRIDED_ND_ADDRESS_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SNDAG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication, checked out of reset
`define SNDAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

/* sv/sndag_pkg.sv */
// types, constants and helper functions of the strided address generator
`timescale 1ns / 1ps

package sndag_pkg;

	localparam int HW_DIMS    = 4;
	localparam int HW_IDX_W   = $clog2(HW_DIMS);
	localparam int IDX_W      = 16;
	localparam int SIZE_W     = 16;
	localparam int STRIDE_W   = 40;
	localparam int OUT_ADDR_W = 48;
	localparam int DIMS_W     = 3;
	localparam int EB_W       = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PROD_W     = IDX_W + STRIDE_W;
	localparam int CONTIG_W   = STRIDE_W + SIZE_W;
	localparam int CALC_W     = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIMS_USED     = 3'd0,
		REG_ELEMENT_BYTES = 3'd1,
		REG_BASE_ADDRESS  = 3'd2,
		REG_DIM_SIZES     = 3'd3,
		REG_STRIDE_DIM0   = 3'd4,
		REG_STRIDE_DIM1   = 3'd5,
		REG_STRIDE_DIM2   = 3'd6,
		REG_STRIDE_DIM3   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [DIMS_W-1:0]                 dims_used;
		logic [EB_W-1:0]                   element_bytes;
		logic [OUT_ADDR_W-1:0]             base_address;
		logic [HW_DIMS-1:0][SIZE_W-1:0]    dim_sizes;
		logic [HW_DIMS-1:0][STRIDE_W-1:0]  stride;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dims_used:     3'd1,
		element_bytes: 4'd4,
		base_address:  48'd0,
		dim_sizes:     64'h0001_0001_0001_0001,
		stride:        {HW_DIMS{40'd1}}
	};

	// zero means one, anything above the cap saturates
	function automatic logic [DIMS_W-1:0] active_dims(input logic [DIMS_W-1:0] dims_used,
			input logic [DIMS_W-1:0] cap);
		logic [DIMS_W-1:0] n;
		n = (dims_used == '0) ? DIMS_W'(1) : dims_used;
		if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

	// a size of zero walks as a size of one
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		return (s == '0) ? SIZE_W'(1) : s;
	endfunction

endpackage

/* sv/sndag_if.sv */
// valid/ready channel interfaces for command and response words
`timescale 1ns / 1ps

interface sndag_cmd_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface sndag_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [sndag_pkg::OUT_ADDR_W-1:0]  byte_address;
	logic                              last_element;
	logic                              is_contiguous;

	modport source (output valid, output byte_address, output last_element,
		output is_contiguous, input ready);
	modport sink (input valid, input byte_address, input last_element,
		input is_contiguous, output ready);
endinterface

/* sv/sndag_index_walker.sv */
// odometer of per-dimension index counters with last-element detect
`timescale 1ns / 1ps

module sndag_index_walker #(
	parameter int NDIM = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic                                  restart,
	input  sndag_pkg::cfg_t                       cfg,
	output logic [NDIM-1:0][sndag_pkg::IDX_W-1:0] cur,
	output logic                                  last
);

	logic [NDIM-1:0][sndag_pkg::IDX_W-1:0] idx_q;
	logic [NDIM-1:0][sndag_pkg::IDX_W-1:0] nxt;
	logic [NDIM-1:0]                       wrap;
	logic [sndag_pkg::DIMS_W-1:0]          n;
	logic                                  carry;

	always_comb begin
		n    = sndag_pkg::active_dims(cfg.dims_used, sndag_pkg::DIMS_W'(NDIM));
		cur  = restart ? '0 : idx_q;
		nxt  = cur;
		last = 1'b1;
		carry = 1'b0;
		for (int d = 0; d < NDIM; d++) begin
			// an index at or past its final value counts as final
			wrap[d] = ({1'b0, cur[d]} + (sndag_pkg::IDX_W+1)'(1))
				>= {1'b0, sndag_pkg::eff_size(cfg.dim_sizes[d])};
		end
		// innermost used dimension first, carry outward
		for (int d = NDIM - 1; d >= 0; d--) begin
			if (sndag_pkg::DIMS_W'(d) < n) begin
				if (!wrap[d]) begin
					last = 1'b0;
				end
				if (sndag_pkg::DIMS_W'(d) == n - sndag_pkg::DIMS_W'(1)) begin
					carry = 1'b1;
				end
				if (carry) begin
					if (wrap[d]) begin
						nxt[d] = '0;
					end else begin
						nxt[d] = cur[d] + sndag_pkg::IDX_W'(1);
						carry  = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= nxt;
		end
	end

endmodule

/* sv/strided_nd_address_generator.sv */
// top level of the strided n-dimensional address generator
`timescale 1ns / 1ps

// Strided address generator: every command word yields one response word holding the byte
// address of the current element of a tensor of up to four dimensions, walked in row-major
// order (dimension 0 outermost), plus a last-element flag and a contiguity flag. The address
// is base_address + element_bytes * sum(index[d] * stride[d]) over the used dimensions,
// wrapped to ADDR_BITS and shown on 48 bits. A command with restart set clears the indices
// before the address is formed; the walk wraps to the start after the last element.
// One command is taken every clock cycle while the response side is not stalled. The path is four
// registers deep: index snapshot, index-times-stride products, their sum, then the scaled
// address in the output register. The index odometer is the only loop-carried state and
// its next value is combinational, which is what sets the one-word-per-cycle rate.
// Configuration registers are written through a plain write port (cfg_we, cfg_index,
// cfg_wdata) and must only change while no command is in flight.

module strided_nd_address_generator #(
	parameter int MAX_DIMS  = 4,
	parameter int ADDR_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	sndag_cmd_if.sink                           cmd,
	sndag_rsp_if.source                         rsp,
	input  logic                                cfg_we,
	input  logic [sndag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sndag_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// only the first four dimensions ever take part in the walk
	localparam int NDIM = (MAX_DIMS < sndag_pkg::HW_DIMS) ? MAX_DIMS : sndag_pkg::HW_DIMS;
	localparam int SUM_W = sndag_pkg::PROD_W + $clog2(NDIM);
	localparam int SCALE_W = SUM_W + sndag_pkg::EB_W;
	localparam logic [sndag_pkg::CALC_W-1:0] AMASK =
		{sndag_pkg::CALC_W{1'b1}} >> (sndag_pkg::CALC_W - ADDR_BITS);

	// configuration registers
	sndag_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= sndag_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (sndag_pkg::reg_idx_t'(cfg_index))
				sndag_pkg::REG_DIMS_USED: begin
					cfg_q.dims_used <= cfg_wdata[sndag_pkg::DIMS_W-1:0];
				end
				sndag_pkg::REG_ELEMENT_BYTES: begin
					cfg_q.element_bytes <= cfg_wdata[sndag_pkg::EB_W-1:0];
				end
				sndag_pkg::REG_BASE_ADDRESS: begin
					cfg_q.base_address <= cfg_wdata[sndag_pkg::OUT_ADDR_W-1:0];
				end
				sndag_pkg::REG_DIM_SIZES: begin
					cfg_q.dim_sizes <= cfg_wdata;
				end
				sndag_pkg::REG_STRIDE_DIM0: begin
					cfg_q.stride[0] <= cfg_wdata[sndag_pkg::STRIDE_W-1:0];
				end
				sndag_pkg::REG_STRIDE_DIM1: begin
					cfg_q.stride[1] <= cfg_wdata[sndag_pkg::STRIDE_W-1:0];
				end
				sndag_pkg::REG_STRIDE_DIM2: begin
					cfg_q.stride[2] <= cfg_wdata[sndag_pkg::STRIDE_W-1:0];
				end
				sndag_pkg::REG_STRIDE_DIM3: begin
					cfg_q.stride[3] <= cfg_wdata[sndag_pkg::STRIDE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic [sndag_pkg::DIMS_W-1:0] n;
	assign n = sndag_pkg::active_dims(cfg_q.dims_used, sndag_pkg::DIMS_W'(NDIM));

	// stage enables: a stage moves when it is empty or the one after it moves
	logic v_s1, v_s2, v_s3, out_v_q;
	logic en_s1, en_s2, en_s3, en_out;
	logic cmd_fire;

	assign en_out   = !out_v_q || rsp.ready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign cmd.ready = en_s1;
	assign cmd_fire = cmd.valid && en_s1;

	// index odometer, advanced once per accepted command word
	logic [NDIM-1:0][sndag_pkg::IDX_W-1:0] cur_idx;
	logic                                  cur_last;

	sndag_index_walker #(
		.NDIM (NDIM)
	) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (cmd_fire),
		.restart (cmd.restart),
		.cfg     (cfg_q),
		.cur     (cur_idx),
		.last    (cur_last)
	);

	// stage 1: snapshot of the indices for this word
	logic [NDIM-1:0][sndag_pkg::IDX_W-1:0] idx_s1;
	logic                                  last_s1;

	// stage 2: index-times-stride products and contiguity products
	logic [NDIM-1:0][sndag_pkg::PROD_W-1:0]   prod;
	logic [NDIM-1:0][sndag_pkg::CONTIG_W-1:0] cprod;
	logic [NDIM-1:0][sndag_pkg::PROD_W-1:0]   prod_s2;
	logic [NDIM-1:0][sndag_pkg::CONTIG_W-1:0] cprod_s2;
	logic                                     last_s2;

	// stage 3: offset sum and contiguity flag
	logic [SUM_W-1:0] sum;
	logic [NDIM-1:0]  dim_ok;
	logic [SUM_W-1:0] sum_s3;
	logic             contig_s3;
	logic             last_s3;

	// output register
	logic [SCALE_W-1:0]                scaled;
	logic [sndag_pkg::CALC_W-1:0]      addr_full;
	logic [sndag_pkg::OUT_ADDR_W-1:0]  addr_q;
	logic                              last_q;
	logic                              contig_q;

	always_comb begin
		for (int d = 0; d < NDIM; d++) begin
			// unused dimensions contribute nothing
			if (sndag_pkg::DIMS_W'(d) < n) begin
				prod[d] = sndag_pkg::PROD_W'(idx_s1[d])
					* sndag_pkg::PROD_W'(cfg_q.stride[d]);
			end else begin
				prod[d] = '0;
			end
			// stride the next-inner dimension implies for this one
			cprod[d] = sndag_pkg::CONTIG_W'(cfg_q.stride[sndag_pkg::HW_IDX_W'(d + 1)])
				* sndag_pkg::CONTIG_W'(sndag_pkg::eff_size(
					cfg_q.dim_sizes[sndag_pkg::HW_IDX_W'(d + 1)]));
		end
	end

	always_comb begin
		sum = '0;
		for (int d = 0; d < NDIM; d++) begin
			sum = sum + SUM_W'(prod_s2[d]);
			// contiguous when the innermost stride is one and each outer stride
			// equals the inner stride times the inner size
			if (sndag_pkg::DIMS_W'(d) >= n) begin
				dim_ok[d] = 1'b1;
			end else if (sndag_pkg::DIMS_W'(d) == n - sndag_pkg::DIMS_W'(1)) begin
				dim_ok[d] = (cfg_q.stride[d] == sndag_pkg::STRIDE_W'(1));
			end else begin
				dim_ok[d] = (sndag_pkg::CONTIG_W'(cfg_q.stride[d]) == cprod_s2[d]);
			end
		end
	end

	always_comb begin
		// element size is four bits: shift-and-add
		scaled = '0;
		for (int b = 0; b < sndag_pkg::EB_W; b++) begin
			if (cfg_q.element_bytes[b]) begin
				scaled = scaled + (SCALE_W'(sum_s3) << b);
			end
		end
		addr_full = (sndag_pkg::CALC_W'(cfg_q.base_address) + sndag_pkg::CALC_W'(scaled))
			& AMASK;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= cmd_fire;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_s1  <= cur_idx;
			last_s1 <= cur_last;
		end
		if (en_s2) begin
			prod_s2  <= prod;
			cprod_s2 <= cprod;
			last_s2  <= last_s1;
		end
		if (en_s3) begin
			sum_s3    <= sum;
			contig_s3 <= &dim_ok;
			last_s3   <= last_s2;
		end
		if (en_out) begin
			addr_q   <= addr_full[sndag_pkg::OUT_ADDR_W-1:0];
			last_q   <= last_s3;
			contig_q <= contig_s3;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.byte_address  = addr_q;
	assign rsp.last_element  = last_q;
	assign rsp.is_contiguous = contig_q;

endmodule

/* sv/sndag_checker.sv */
// port-level checker for the strided address generator, bound to the top level
`timescale 1ns / 1ps
`include "strided_nd_address_generator_assert.svh"

module sndag_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cmd_valid,
	input logic                                cmd_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [sndag_pkg::OUT_ADDR_W-1:0]    rsp_byte_address,
	input logic                                rsp_last_element,
	input logic                                rsp_is_contiguous
);

	// words accepted but not yet delivered; the datapath holds four at most
	localparam logic [2:0] DEPTH = 3'd4;

	logic [2:0] pending_q;
	logic       cmd_fire;
	logic       rsp_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_fire && !rsp_fire) begin
			pending_q <= pending_q + 3'd1;
		end else if (!cmd_fire && rsp_fire) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	// a stalled response word holds its value
	`SNDAG_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_byte_address) && $stable(rsp_last_element)
		&& $stable(rsp_is_contiguous))

	// a free output slot lets the whole pipe move, so a command is always taken
	`SNDAG_ASSERT_IMPL(a_cmd_ready, clk, arst_n, !rsp_valid || rsp_ready, cmd_ready)

	// no response word without a command word behind it
	`SNDAG_ASSERT_IMPL(a_no_orphan, clk, arst_n, rsp_valid, pending_q != 3'd0)

	// never more words in flight than pipeline slots
	`SNDAG_ASSERT_IMPL(a_depth, clk, arst_n, cmd_fire, pending_q <= DEPTH)

endmodule

bind strided_nd_address_generator sndag_checker u_sndag_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_byte_address  (rsp.byte_address),
	.rsp_last_element  (rsp.last_element),
	.rsp_is_contiguous (rsp.is_contiguous)
);

/* tb/sndag_addr_checker.sv */
// scoreboard that mirrors the address walk and checks every response word
`timescale 1ns / 1ps

module sndag_addr_checker #(
	parameter int MAX_DIMS  = 4,
	parameter int ADDR_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sndag_cmd_if                              cmd,
	sndag_rsp_if                              rsp,
	input  logic                              cfg_we,
	input  logic [sndag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sndag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output int                                mismatches,
	output int                                pending
);
	import sndag_pkg::*;

	localparam int DIM_CAP = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
	localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? ~64'd0 :
		((64'd1 << ADDR_BITS) - 64'd1);

	typedef struct packed {
		logic [OUT_ADDR_W-1:0] byte_address;
		logic                  last_element;
		logic                  is_contiguous;
	} elem_word_t;

	cfg_t             regs;
	logic [IDX_W-1:0] walk_idx [MAX_DIMS];
	elem_word_t       expected_words [$];

	// zero size walks as one
	function automatic logic [SIZE_W:0] dim_extent(input int d);
		return (regs.dim_sizes[d] == '0) ? (SIZE_W+1)'(1) : {1'b0, regs.dim_sizes[d]};
	endfunction

	// address and flags of the current element, then step the odometer
	function automatic elem_word_t next_element_word(input logic restart);
		elem_word_t       w;
		int               n;
		int               d;
		logic [63:0]      offset;
		logic [63:0]      span;
		logic [IDX_W:0]   bumped;
		n = (regs.dims_used == '0) ? 1 : int'(regs.dims_used);
		if (n > DIM_CAP) begin
			n = DIM_CAP;
		end
		if (restart) begin
			for (d = 0; d < MAX_DIMS; d++) begin
				walk_idx[d] = '0;
			end
		end
		offset = '0;
		w.last_element = 1'b1;
		for (d = 0; d < n; d++) begin
			offset += 64'(walk_idx[d]) * 64'(regs.stride[d]);
			if ((IDX_W+1)'(walk_idx[d]) + (IDX_W+1)'(1) < dim_extent(d)) begin
				w.last_element = 1'b0;
			end
		end
		w.byte_address = OUT_ADDR_W'((64'(regs.base_address) + 64'(regs.element_bytes) * offset)
			& ADDR_MASK);
		w.is_contiguous = 1'b1;
		span = 64'd1;
		for (d = n - 1; d >= 0; d--) begin
			if (64'(regs.stride[d]) != span) begin
				w.is_contiguous = 1'b0;
				break;
			end
			span = span * 64'(dim_extent(d));
		end
		for (d = n - 1; d >= 0; d--) begin
			bumped = (IDX_W+1)'(walk_idx[d]) + (IDX_W+1)'(1);
			if (bumped < dim_extent(d)) begin
				walk_idx[d] = bumped[IDX_W-1:0];
				break;
			end
			walk_idx[d] = '0;
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		elem_word_t want;
		if (!arst_n) begin
			regs = CFG_RESET;
			for (int d = 0; d < MAX_DIMS; d++) begin
				walk_idx[d] = '0;
			end
			expected_words.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_DIMS_USED:     regs.dims_used     = cfg_wdata[DIMS_W-1:0];
					REG_ELEMENT_BYTES: regs.element_bytes = cfg_wdata[EB_W-1:0];
					REG_BASE_ADDRESS:  regs.base_address  = cfg_wdata[OUT_ADDR_W-1:0];
					REG_DIM_SIZES:     regs.dim_sizes     = cfg_wdata;
					REG_STRIDE_DIM0:   regs.stride[0]     = cfg_wdata[STRIDE_W-1:0];
					REG_STRIDE_DIM1:   regs.stride[1]     = cfg_wdata[STRIDE_W-1:0];
					REG_STRIDE_DIM2:   regs.stride[2]     = cfg_wdata[STRIDE_W-1:0];
					REG_STRIDE_DIM3:   regs.stride[3]     = cfg_wdata[STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word: expected none,", $time,
						" actual addr %h last %b contig %b",
						rsp.byte_address, rsp.last_element, rsp.is_contiguous);
				end else begin
					want = expected_words.pop_front();
					if (rsp.byte_address !== want.byte_address ||
							rsp.last_element !== want.last_element ||
							rsp.is_contiguous !== want.is_contiguous) begin
						mismatches++;
						$display("%0t: expected addr %h last %b contig %b,", $time,
							want.byte_address, want.last_element, want.is_contiguous,
							" actual addr %h last %b contig %b",
							rsp.byte_address, rsp.last_element, rsp.is_contiguous);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				expected_words.push_back(next_element_word(cmd.restart));
			end
			pending = expected_words.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// stimulus and verdict for the strided address generator testbench
`timescale 1ns / 1ps

module tb_top;
	import sndag_pkg::*;

	// sized from ~1000 words, each waiting out the longest gap and the longest stall,
	// plus register loads between phases, then taken several times over
	localparam int CYCLE_LIMIT = 200000;
	// pipeline is four deep; leave room to catch stray words
	localparam int TAIL_CYCLES = 12;
	localparam int RANDOM_WORDS = 850;
	localparam int STEADY_WORDS = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int          mismatches;
	int          pending;
	int unsigned cycles = 0;
	// one in n chance of an idle burst per word or cycle; zero turns idling off
	int unsigned send_gap_odds = 4;
	int unsigned stall_odds = 4;

	sndag_cmd_if cmd_ch ();
	sndag_rsp_if rsp_ch ();

	strided_nd_address_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// the checker sees the same channels and register writes as the block
	sndag_addr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// response side: ready drops in bursts of random length
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 8);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// one command word; called and returning at a falling edge, valid left high
	// so that back-to-back words need no second assignment in one step
	task automatic send_word(input logic restart_bit);
		if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.restart <= restart_bit;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// a run of words along the walk; restart_odds of zero means no restarts after the first
	task automatic send_walk(input int count, input logic first_restart,
			input int unsigned restart_odds);
		for (int k = 0; k < count; k++) begin
			if (k == 0) begin
				send_word(first_restart);
			end else begin
				send_word(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
			end
		end
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// registers may only change with nothing in flight: stop sending and let
	// every expected word come back first; the walk indices carry across loads
	task automatic load_setting(input cfg_t s);
		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		put_reg(REG_DIMS_USED,     CFG_DATA_W'(s.dims_used));
		put_reg(REG_ELEMENT_BYTES, CFG_DATA_W'(s.element_bytes));
		put_reg(REG_BASE_ADDRESS,  CFG_DATA_W'(s.base_address));
		put_reg(REG_DIM_SIZES,     CFG_DATA_W'(s.dim_sizes));
		put_reg(REG_STRIDE_DIM0,   CFG_DATA_W'(s.stride[0]));
		put_reg(REG_STRIDE_DIM1,   CFG_DATA_W'(s.stride[1]));
		put_reg(REG_STRIDE_DIM2,   CFG_DATA_W'(s.stride[2]));
		put_reg(REG_STRIDE_DIM3,   CFG_DATA_W'(s.stride[3]));
		cfg_we <= 1'b0;
	endtask

	// mostly small shapes so walks wrap within a phase; now and then
	// out-of-range counts and element sizes, zero sizes and full-width values
	function automatic cfg_t random_setting();
		cfg_t        s;
		int          n;
		int          d;
		int unsigned shape;
		logic [63:0] span;
		logic [15:0] sz;
		s.dims_used = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) :
			3'($urandom_range(1, 4));
		s.element_bytes = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
		case ($urandom_range(0, 3))
			0: s.base_address = '0;
			// near the top so offsets wrap past 2^48
			1: s.base_address = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4095));
			default: s.base_address = 48'({$urandom, $urandom});
		endcase
		for (d = 0; d < HW_DIMS; d++) begin
			case ($urandom_range(0, 15))
				0: s.dim_sizes[d] = '0;
				1: s.dim_sizes[d] = 16'($urandom);
				default: s.dim_sizes[d] = 16'($urandom_range(1, 5));
			endcase
		end
		n = (s.dims_used == '0) ? 1 : ((s.dims_used > 3'd4) ? 4 : int'(s.dims_used));
		// half the shapes get row-major strides so the contiguity flag is exercised
		shape = $urandom_range(0, 3);
		span = 64'd1;
		for (d = HW_DIMS - 1; d >= 0; d--) begin
			if (shape < 2 && d < n) begin
				s.stride[d] = span[STRIDE_W-1:0];
				sz = (s.dim_sizes[d] == '0) ? 16'd1 : s.dim_sizes[d];
				span = span * 64'(sz);
			end else if (shape == 2) begin
				s.stride[d] = STRIDE_W'({$urandom, $urandom});
			end else begin
				s.stride[d] = STRIDE_W'($urandom_range(0, 7));
			end
		end
		return s;
	endfunction

	initial begin
		cfg_t s;
		int   sent;
		int   count;
		cmd_ch.valid = 1'b0;
		cmd_ch.restart = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: single element, stride one, so every word is base and last
		send_word(1'b0);
		send_word(1'b1);

		// 2x3 walk, row-major, from just under the top of the address space
		s = CFG_RESET;
		s.dims_used = 3'd2;
		s.element_bytes = 4'd8;
		s.base_address = 48'hFFFF_FFFF_FFF0;
		s.dim_sizes[0] = 16'd2;
		s.dim_sizes[1] = 16'd3;
		s.stride[0] = 40'd3;
		s.stride[1] = 40'd1;
		load_setting(s);
		send_walk(7, 1'b1, 0);

		// all fields at their top: count saturates, element size past eight,
		// largest base, sizes and strides, and a zero size on the last dimension
		s.dims_used = 3'd7;
		s.element_bytes = 4'hF;
		s.base_address = '1;
		s.dim_sizes = {16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		s.stride = '1;
		load_setting(s);
		send_walk(3, 1'b1, 0);

		// zero dimension count walks one dimension, zero element size pins the base
		s = CFG_RESET;
		s.dims_used = 3'd0;
		s.element_bytes = 4'd0;
		s.base_address = 48'h1234_5678_9ABC;
		s.dim_sizes[0] = 16'd3;
		s.stride[0] = 40'd5;
		load_setting(s);
		send_walk(4, 1'b1, 0);

		// walk partway into eight elements, then shrink to two without a restart:
		// the held index is past the end, reads as last and wraps to zero
		s = CFG_RESET;
		s.element_bytes = 4'd1;
		s.base_address = 48'h1000;
		s.dim_sizes[0] = 16'd8;
		load_setting(s);
		send_walk(5, 1'b1, 0);
		s.dim_sizes[0] = 16'd2;
		load_setting(s);
		send_walk(3, 1'b0, 0);

		// random phases; idling varies per phase, some phases have none
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			send_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
			stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
			count = $urandom_range(10, 60);
			load_setting(random_setting());
			send_walk(count, $urandom_range(0, 3) == 0, 16);
			sent += count;
		end

		// closing stretch at full rate, no idling on either side
		send_gap_odds = 0;
		stall_odds = 0;
		load_setting(random_setting());
		send_walk(STEADY_WORDS, 1'b0, 16);

		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
